// ===== design/assert_macros.svh =====
// assertion macros used by the station learning table datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/wslt_pkg.sv =====
// types and constants of the station learning table
package wslt_pkg;

   localparam int ADDR_W   = 48;
   localparam int FLAGS_W  = 8;
   localparam int RAW_W    = 8;
   localparam int LEVEL_W  = 9;
   localparam int INDEX_W  = 5;
   localparam int USED_W   = 6;

   localparam logic [FLAGS_W-1:0] FLAGS_TO_DS     = 8'h01;
   localparam logic [FLAGS_W-1:0] FLAGS_TO_DS_ALT = 8'h11;
   localparam logic [FLAGS_W-1:0] FLAGS_NO_DS     = 8'h00;
   localparam logic [FLAGS_W-1:0] FLAGS_NO_DS_ALT = 8'h10;
   localparam logic [LEVEL_W-1:0] LEVEL_BIAS      = 9'h100;

   typedef enum logic [1:0] {
      ST_INSERTED = 2'd0,
      ST_UPDATED  = 2'd1,
      ST_DROPPED  = 2'd2,
      ST_IGNORED  = 2'd3
   } status_type;

   typedef struct packed {
      logic       load;
      logic       scan;
      logic       set_code;
      status_type code;
      logic       emit;
   } dp_cmd_type;

   typedef struct packed {
      logic ignore;
      logic empty;
      logic hit;
      logic last;
      logic full;
   } dp_sts_type;

endpackage

// ===== design/wslt_ctrl.sv =====
// controller state machine of the station learning table
module wslt_ctrl
   import wslt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  dp_sts_type sts,
   output dp_cmd_type cmd
);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_CHECK  = 4'b0010,
      S_SCAN   = 4'b0100,
      S_FINISH = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.code = ST_INSERTED;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (sts.ignore) begin
               cmd.set_code = 1'b1;
               cmd.code     = ST_IGNORED;
               state_in     = S_FINISH;
            end else if (sts.empty) begin
               cmd.set_code = 1'b1;
               cmd.code     = ST_INSERTED;
               state_in     = S_FINISH;
            end else begin
               cmd.scan = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.hit) begin
               cmd.set_code = 1'b1;
               cmd.code     = ST_UPDATED;
               state_in     = S_FINISH;
            end else if (sts.last) begin
               cmd.set_code = 1'b1;
               cmd.code     = sts.full ? ST_DROPPED : ST_INSERTED;
               state_in     = S_FINISH;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.emit || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== design/wslt_datapath.sv =====
// datapath of the station learning table: request latch, station memories, scan and result
module wslt_datapath
   import wslt_pkg::*;
#(
   parameter int TABLE_ENTRIES = 32
)
(
   input  logic               clock,
   input  logic               reset,
   input  dp_cmd_type         cmd,
   output dp_sts_type         sts,
   input  logic [FLAGS_W-1:0] req_frame_flags,
   input  logic [ADDR_W-1:0]  req_addr_one,
   input  logic [ADDR_W-1:0]  req_addr_two,
   input  logic [RAW_W-1:0]   req_signal_raw,
   output logic [1:0]         rsp_status,
   output logic [INDEX_W-1:0] rsp_entry_index,
   output logic [USED_W-1:0]  rsp_entries_used
);

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

   logic [ADDR_W-1:0]  mac_mem   [TABLE_ENTRIES];
   logic [ADDR_W-1:0]  bssid_mem [TABLE_ENTRIES];
   logic [LEVEL_W-1:0] level_mem [TABLE_ENTRIES];

   logic [ADDR_W-1:0]  mac_ff, mac_in;
   logic [ADDR_W-1:0]  bssid_ff, bssid_in;
   logic [LEVEL_W-1:0] level_ff;
   logic               ignore_ff, ignore_in;
   logic               to_ds, no_ds;

   logic [CNT_W-1:0]   fill_ff, fill_in;
   logic [IDX_W-1:0]   scan_idx_ff, scan_idx_in;
   logic [IDX_W-1:0]   cmp_idx_ff;
   logic               cmp_valid_ff, cmp_valid_in;
   logic [ADDR_W-1:0]  rd_mac_ff;

   status_type         res_code_ff;
   logic [IDX_W-1:0]   res_idx_ff, res_idx_in;

   logic [1:0]         rsp_status_ff;
   logic [INDEX_W-1:0] rsp_entry_index_ff;
   logic [USED_W-1:0]  rsp_entries_used_ff;

   logic               do_insert, do_update, level_we;
   logic [IDX_W-1:0]   fill_idx, level_idx;

   // address roles from the flags byte
   assign to_ds = req_frame_flags inside {FLAGS_TO_DS, FLAGS_TO_DS_ALT};
   assign no_ds = req_frame_flags inside {FLAGS_NO_DS, FLAGS_NO_DS_ALT};
   assign ignore_in = !(to_ds || no_ds);
   assign mac_in    = to_ds ? req_addr_two : req_addr_one;
   assign bssid_in  = to_ds ? req_addr_one : req_addr_two;

   assign fill_idx  = fill_ff[IDX_W-1:0];
   assign do_insert = cmd.set_code && (cmd.code == ST_INSERTED);
   assign do_update = cmd.set_code && (cmd.code == ST_UPDATED);
   assign level_we  = do_insert || do_update;
   assign level_idx = do_update ? cmp_idx_ff : fill_idx;

   assign sts.ignore = ignore_ff;
   assign sts.empty  = (fill_ff == '0);
   assign sts.full   = (fill_ff == CNT_W'(TABLE_ENTRIES));
   assign sts.hit    = cmp_valid_ff && (rd_mac_ff == mac_ff);
   assign sts.last   = cmp_valid_ff && ((CNT_W'(cmp_idx_ff) + CNT_W'(1)) == fill_ff);

   assign fill_in      = do_insert ? fill_ff + CNT_W'(1) : fill_ff;
   assign scan_idx_in  = cmd.load ? '0 : (cmd.scan ? scan_idx_ff + IDX_W'(1) : scan_idx_ff);
   assign cmp_valid_in = cmd.load ? 1'b0 : (cmd.scan ? 1'b1 : cmp_valid_ff);

   always_comb begin
      res_idx_in = '0;
      if (do_insert) begin
         res_idx_in = fill_idx;
      end else if (do_update) begin
         res_idx_in = cmp_idx_ff;
      end
   end

   // station memories
   always_ff @(posedge clock) begin
      if (do_insert) begin
         mac_mem[fill_idx]   <= mac_ff;
         bssid_mem[fill_idx] <= bssid_ff;
      end
      if (level_we) begin
         level_mem[level_idx] <= level_ff;
      end
      rd_mac_ff <= mac_mem[scan_idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         scan_idx_ff  <= '0;
         cmp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         scan_idx_ff  <= scan_idx_in;
         cmp_valid_ff <= cmp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mac_ff    <= mac_in;
         bssid_ff  <= bssid_in;
         level_ff  <= {1'b0, req_signal_raw} - LEVEL_BIAS;
         ignore_ff <= ignore_in;
      end
      if (cmd.scan) begin
         cmp_idx_ff <= scan_idx_ff;
      end
      if (cmd.set_code) begin
         res_code_ff <= cmd.code;
         res_idx_ff  <= res_idx_in;
      end
      if (cmd.emit) begin
         rsp_status_ff       <= res_code_ff;
         rsp_entry_index_ff  <= INDEX_W'(res_idx_ff);
         rsp_entries_used_ff <= USED_W'(fill_ff);
      end
   end

   assign rsp_status       = rsp_status_ff;
   assign rsp_entry_index  = rsp_entry_index_ff;
   assign rsp_entries_used = rsp_entries_used_ff;

`include "assert_macros.svh"

   `ASSERT_ALWAYS(a_fill_bound, clock, reset, fill_ff <= CNT_W'(TABLE_ENTRIES), "fill count beyond table size")
   `ASSERT_NEXT(a_insert_count, clock, reset, do_insert, fill_ff == $past(fill_ff) + CNT_W'(1), "insert did not advance fill count")
   `ASSERT_IMPLY(a_update_on_hit, clock, reset, do_update, cmp_valid_ff && (rd_mac_ff == mac_ff), "update without a matching entry")

endmodule

// ===== design/wifi_station_learning_table.sv =====
// top level of the wireless station learning table
// steps: load, check, scan of up to TABLE_ENTRIES stored stations (skipped if empty or ignored), emit
// the scan reads one station memory entry per cycle; new requests wait until the result is emitted
// a finished result waits in the output register while the next request is taken
// reset: synchronous, active high; clears the station count and the handshake state
// memory contents are not cleared: entries beyond the station count are never read
module wifi_station_learning_table
   import wslt_pkg::*;
#(
   parameter int TABLE_ENTRIES = 32
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [FLAGS_W-1:0] req_frame_flags,
   input  logic [ADDR_W-1:0]  req_addr_one,
   input  logic [ADDR_W-1:0]  req_addr_two,
   input  logic [RAW_W-1:0]   req_signal_raw,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic [INDEX_W-1:0] rsp_entry_index,
   output logic [USED_W-1:0]  rsp_entries_used
);

   dp_cmd_type cmd;
   dp_sts_type sts;

   wslt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   wslt_datapath #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_frame_flags  (req_frame_flags),
      .req_addr_one     (req_addr_one),
      .req_addr_two     (req_addr_two),
      .req_signal_raw   (req_signal_raw),
      .rsp_status       (rsp_status),
      .rsp_entry_index  (rsp_entry_index),
      .rsp_entries_used (rsp_entries_used)
   );

endmodule

// ===== sim/tb.sv =====
// testbench of the station learning table: scoreboard with its own table predictor
`timescale 1ns / 1ps

module tb;
   import wslt_pkg::*;

   localparam int TABLE_SLOTS = 32;
   localparam int POOL_SIZE   = 40;
   localparam int QUIET_LIMIT = 4000;
   localparam int RANDOM_FRAMES = 1700;

   typedef struct packed {
      status_type           status;
      logic [INDEX_W-1:0]   index;
      logic [USED_W-1:0]    used;
   } table_result_type;

   class station_scoreboard;
      logic [ADDR_W-1:0] known_mac[TABLE_SLOTS];
      int                stations;
      table_result_type  expected_q[$];
      int                mismatches;

      function new();
         stations   = 0;
         mismatches = 0;
      endfunction

      function void note_request(input logic [FLAGS_W-1:0] flags,
                                 input logic [ADDR_W-1:0] a1,
                                 input logic [ADDR_W-1:0] a2);
         table_result_type  r;
         logic [ADDR_W-1:0] mac;
         bit                found;
         r.status = ST_IGNORED;
         r.index  = '0;
         found    = 0;
         mac      = (flags == FLAGS_TO_DS || flags == FLAGS_TO_DS_ALT) ? a2 : a1;
         if (flags inside {FLAGS_TO_DS, FLAGS_TO_DS_ALT, FLAGS_NO_DS, FLAGS_NO_DS_ALT}) begin
            r.status = ST_DROPPED;
            for (int i = 0; i < stations; i++) begin
               if (!found && known_mac[i] == mac) begin
                  found    = 1;
                  r.status = ST_UPDATED;
                  r.index  = INDEX_W'(i);
               end
            end
            if (!found && stations < TABLE_SLOTS) begin
               known_mac[stations] = mac;
               r.status = ST_INSERTED;
               r.index  = INDEX_W'(stations);
               stations++;
            end
         end
         r.used = USED_W'(stations);
         expected_q.push_back(r);
      endfunction

      function void check_response(input logic [1:0] status,
                                   input logic [INDEX_W-1:0] index,
                                   input logic [USED_W-1:0] used);
         table_result_type r;
         if (expected_q.size() == 0) begin
            $error("response with no request outstanding: status %0d", status);
            mismatches++;
            return;
         end
         r = expected_q.pop_front();
         if (status !== r.status) begin
            $error("status: expected %0d, actual %0d", r.status, status);
            mismatches++;
         end
         if (index !== r.index) begin
            $error("entry_index: expected %0d, actual %0d", r.index, index);
            mismatches++;
         end
         if (used !== r.used) begin
            $error("entries_used: expected %0d, actual %0d", r.used, used);
            mismatches++;
         end
      endfunction

      function int outstanding();
         return expected_q.size();
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [FLAGS_W-1:0] req_frame_flags = '0;
   logic [ADDR_W-1:0]  req_addr_one = '0;
   logic [ADDR_W-1:0]  req_addr_two = '0;
   logic [RAW_W-1:0]   req_signal_raw = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [1:0]         rsp_status;
   logic [INDEX_W-1:0] rsp_entry_index;
   logic [USED_W-1:0]  rsp_entries_used;

   station_scoreboard sb = new();
   logic [ADDR_W-1:0] station_pool[POOL_SIZE];
   logic [ADDR_W-1:0] bssid_pool[4];
   int                pool_used = 0;
   int                burst_left = 0;
   int                quiet_cycles = 0;
   int unsigned       stall_phase = 0;
   int                stall_mode = 0;

   wifi_station_learning_table #(.TABLE_ENTRIES(TABLE_SLOTS)) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_frame_flags  (req_frame_flags),
      .req_addr_one     (req_addr_one),
      .req_addr_two     (req_addr_two),
      .req_signal_raw   (req_signal_raw),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_entry_index  (rsp_entry_index),
      .rsp_entries_used (rsp_entries_used)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            sb.note_request(req_frame_flags, req_addr_one, req_addr_two);
         if (rsp_valid && !rsp_stall)
            sb.check_response(rsp_status, rsp_entry_index, rsp_entries_used);
      end
   end

   // receiver stall pattern, switching among four random modes
   always @(posedge clock) begin
      stall_phase <= stall_phase + 1;
      if (stall_phase % 256 == 0)
         stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 1) == 1);
         2: rsp_stall <= ($urandom_range(0, 7) != 0);
         default: rsp_stall <= stall_phase[4];
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == QUIET_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   function automatic logic [ADDR_W-1:0] rand_addr();
      return {16'($urandom), 32'($urandom)};
   endfunction

   task automatic send_frame(input logic [FLAGS_W-1:0] flags,
                             input logic [ADDR_W-1:0] a1,
                             input logic [ADDR_W-1:0] a2,
                             input logic [RAW_W-1:0] raw);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 25);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
      end
      burst_left--;
      req_valid       <= 1'b1;
      req_frame_flags <= flags;
      req_addr_one    <= a1;
      req_addr_two    <= a2;
      req_signal_raw  <= raw;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // place station and bssid in the address slots that the flags select
   task automatic send_station(input logic [FLAGS_W-1:0] flags,
                               input logic [ADDR_W-1:0] mac,
                               input logic [ADDR_W-1:0] bssid,
                               input logic [RAW_W-1:0] raw);
      if (flags == FLAGS_TO_DS || flags == FLAGS_TO_DS_ALT)
         send_frame(flags, bssid, mac, raw);
      else
         send_frame(flags, mac, bssid, raw);
   endtask

   initial begin
      logic [FLAGS_W-1:0] flags;
      logic [ADDR_W-1:0]  mac;
      logic [ADDR_W-1:0]  bssid;
      int                 sel;

      foreach (station_pool[i]) station_pool[i] = rand_addr();
      foreach (bssid_pool[i]) bssid_pool[i] = rand_addr();

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed requests
      send_frame(8'h02, '1, '1, 8'hFF);
      send_frame(8'hFF, '0, '1, 8'h00);
      send_station(FLAGS_TO_DS, '1, '0, 8'h00);
      send_station(FLAGS_NO_DS, '0, '1, 8'hFF);
      send_station(FLAGS_TO_DS_ALT, '1, '0, 8'hFF);
      send_station(FLAGS_NO_DS_ALT, '0, '1, 8'h80);
      send_station(FLAGS_NO_DS, '1, 48'h0123_4567_89AB, 8'h01);
      send_station(FLAGS_TO_DS, '0, '1, 8'h7F);
      send_frame(8'h80, rand_addr(), rand_addr(), 8'h55);
      send_frame(8'h21, rand_addr(), rand_addr(), 8'hAA);
      send_frame(8'h03, rand_addr(), rand_addr(), 8'h10);
      send_frame(8'hEF, rand_addr(), rand_addr(), 8'h20);
      send_station(FLAGS_NO_DS_ALT, 48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, 8'h00);
      send_station(FLAGS_TO_DS, 48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA, 8'hFF);

      // random requests: mostly known or new stations, some noise
      for (int n = 0; n < RANDOM_FRAMES; n++) begin
         sel = $urandom_range(0, 99);
         if (sel < 15) begin
            send_frame(8'($urandom_range(0, 255)), rand_addr(), rand_addr(),
                       8'($urandom_range(0, 255)));
         end else begin
            case ($urandom_range(0, 3))
               0: flags = FLAGS_TO_DS;
               1: flags = FLAGS_TO_DS_ALT;
               2: flags = FLAGS_NO_DS;
               default: flags = FLAGS_NO_DS_ALT;
            endcase
            if (sel < 70 && pool_used > 0) begin
               mac = station_pool[$urandom_range(0, pool_used - 1)];
            end else if (sel < 88) begin
               if (pool_used < POOL_SIZE) begin
                  mac = station_pool[pool_used];
                  pool_used++;
               end else begin
                  mac = station_pool[$urandom_range(0, POOL_SIZE - 1)];
               end
            end else begin
               mac = rand_addr();
            end
            bssid = ($urandom_range(0, 4) == 0) ? rand_addr()
                                                : bssid_pool[$urandom_range(0, 3)];
            send_station(flags, mac, bssid, 8'($urandom_range(0, 255)));
         end
      end

      req_valid <= 1'b0;
      // let the last request reach the scoreboard before draining
      @(posedge clock);
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (sb.mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

// ===== wifi_station_learning_table.f =====
+incdir+design
design/wslt_pkg.sv
design/wslt_ctrl.sv
design/wslt_datapath.sv
design/wifi_station_learning_table.sv
sim/tb.sv
